[design/text_mode_terminal_writer_macros.svh]
// assertion macros for the text mode terminal writer checker
// every property is clocked on clk and switched off while rst is high
`ifndef TEXT_MODE_TERMINAL_WRITER_MACROS_SVH
`define TEXT_MODE_TERMINAL_WRITER_MACROS_SVH

// condition in this cycle implies consequence in the same cycle
`define TMTW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition in this cycle implies consequence in the next cycle
`define TMTW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/tmtw_pkg.sv]
// shared constants, word types and state encoding of the text mode terminal writer
// used by the top level and by the port checker
package tmtw_pkg;

  localparam int SCREEN_COLS = 80;
  localparam int SCREEN_ROWS = 25;
  localparam int TAB_WIDTH   = 4;

  localparam int CELL_COUNT = SCREEN_COLS * SCREEN_ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int COL_W      = $clog2(SCREEN_COLS);
  localparam int ROW_W      = $clog2(SCREEN_ROWS);
  localparam int CNT_W      = $clog2(TAB_WIDTH + 1);

  localparam int POS_W  = 11;
  localparam int CHAR_W = 8;
  localparam int CELL_W = 16;

  localparam logic [CELL_W-1:0] BLANK_CELL     = 16'h0F20;
  localparam logic [CHAR_W-1:0] SPACE_CHAR     = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] ATTR_RESET     = 8'h0F;

  localparam logic ACT_PUT  = 1'b0;
  localparam logic ACT_READ = 1'b1;

  typedef struct packed {
    logic              action;
    logic [CHAR_W-1:0] char_code;
    logic [POS_W-1:0]  cell_index;
  } in_word_t;

  typedef struct packed {
    logic [POS_W-1:0]  cursor_pos;
    logic [CELL_W-1:0] read_data;
    logic              scrolled;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PUT,
    ST_BKSP,
    ST_SCROLL,
    ST_RDWAIT,
    ST_FINISH
  } tmtw_state_t;

endpackage

[design/tmtw_ram.sv]
// generic simple dual port ram: one write port, one read port with registered data
// no dependencies
module tmtw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[design/text_mode_terminal_writer.sv]
// text mode terminal writer: cursor control and screen store around one cell ram
// depends on tmtw_pkg and tmtw_ram
//
//   channel  | signals                         | moves
//   ---------+---------------------------------+-------------------------------
//   input    | in_valid, in_stall, in_word     | one put or read word
//   output   | out_valid, out_stall, out_word  | one result word per input word
//   config   | cfg_wr_en, cfg_wr_data          | text attribute byte
//
// after reset a clearing pass writes a blank cell to each of the CELL_COUNT (2000) ram cells with in_stall high
// a glyph goes via ST_PUT, a tab writes TAB_WIDTH spaces in ST_PUT, a backspace via ST_BKSP, a read via ST_RDWAIT
// a newline with no scroll, a backspace at column 0 or a read past the screen goes straight to ST_FINISH
// on each scroll the ram write port blanks the SCREEN_COLS cells of the new bottom row
// scrolling itself moves no data: a base offset rotates the rows in the ram
// a finished word waits in the output register; the next word can enter as it leaves
module text_mode_terminal_writer
  import tmtw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_word,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_word,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  localparam logic [ADDR_W-1:0] LAST_ROW_START = ADDR_W'((SCREEN_ROWS - 1) * SCREEN_COLS);
  localparam logic [ADDR_W-1:0] COLS_A         = ADDR_W'(SCREEN_COLS);

  tmtw_state_t state, state_next;

  logic [COL_W-1:0]  col, col_next;
  logic [ROW_W-1:0]  row, row_next;
  logic [ADDR_W-1:0] lin, lin_next;
  logic [ADDR_W-1:0] base_off, base_off_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [CHAR_W-1:0] glyph, glyph_next;
  logic [ADDR_W-1:0] scr_addr, scr_addr_next;
  logic [COL_W-1:0]  scr_cnt, scr_cnt_next;
  logic [ADDR_W-1:0] clr_addr, clr_addr_next;
  logic              did_scroll, did_scroll_next;
  logic [CELL_W-1:0] res_data, res_data_next;
  logic [7:0]        attr;
  logic              out_valid_next;
  out_word_t         out_word_next;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [CELL_W-1:0] mem_rdata;

  logic out_free;
  logic accept;
  logic [31:0] lin_wide;
  logic [31:0] cell_wide;

  // logical cell to ram address, rows rotated by the base offset
  function automatic logic [ADDR_W-1:0] phys_addr(input logic [ADDR_W-1:0] a,
                                                   input logic [ADDR_W-1:0] b);
    logic [ADDR_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (ADDR_W + 1)'(CELL_COUNT)) begin
      s = s - (ADDR_W + 1)'(CELL_COUNT);
    end
    return s[ADDR_W-1:0];
  endfunction

  tmtw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = !((state == ST_IDLE) || ((state == ST_FINISH) && out_free));
  assign accept    = in_valid && !in_stall;
  assign lin_wide  = 32'(lin);
  assign cell_wide = 32'(in_word.cell_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      col        <= '0;
      row        <= '0;
      lin        <= '0;
      base_off   <= '0;
      did_scroll <= 1'b0;
      out_valid  <= 1'b0;
      attr       <= ATTR_RESET;
    end else begin
      state      <= state_next;
      clr_addr   <= clr_addr_next;
      col        <= col_next;
      row        <= row_next;
      lin        <= lin_next;
      base_off   <= base_off_next;
      did_scroll <= did_scroll_next;
      out_valid  <= out_valid_next;
      if (cfg_wr_en) begin
        attr <= cfg_wr_data;
      end
    end
    count    <= count_next;
    glyph    <= glyph_next;
    scr_addr <= scr_addr_next;
    scr_cnt  <= scr_cnt_next;
    res_data <= res_data_next;
    out_word <= out_word_next;
  end

  always_comb begin
    state_next      = state;
    col_next        = col;
    row_next        = row;
    lin_next        = lin;
    base_off_next   = base_off;
    count_next      = count;
    glyph_next      = glyph;
    scr_addr_next   = scr_addr;
    scr_cnt_next    = scr_cnt;
    clr_addr_next   = clr_addr;
    did_scroll_next = did_scroll;
    res_data_next   = res_data;
    out_valid_next  = out_valid && out_stall;
    out_word_next   = out_word;
    mem_we          = 1'b0;
    mem_waddr       = phys_addr(lin, base_off);
    mem_wdata       = BLANK_CELL;
    mem_re          = 1'b0;
    mem_raddr       = phys_addr(cell_wide[ADDR_W-1:0], base_off);

    unique case (state)
      ST_CLEAR: begin
        mem_we        = 1'b1;
        mem_waddr     = clr_addr;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == ADDR_W'(CELL_COUNT - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
      end
      ST_PUT: begin
        mem_we     = 1'b1;
        mem_wdata  = {attr, glyph};
        count_next = count - 1'b1;
        if (col == COL_W'(SCREEN_COLS - 1)) begin
          col_next = '0;
          if (row == ROW_W'(SCREEN_ROWS - 1)) begin
            // wrapped off the last row: rotate rows, blank the old top row
            lin_next        = LAST_ROW_START;
            scr_addr_next   = base_off;
            scr_cnt_next    = '0;
            base_off_next   = phys_addr(COLS_A, base_off);
            did_scroll_next = 1'b1;
            state_next      = ST_SCROLL;
          end else begin
            row_next   = row + 1'b1;
            lin_next   = lin + 1'b1;
            state_next = (count == CNT_W'(1)) ? ST_FINISH : ST_PUT;
          end
        end else begin
          col_next   = col + 1'b1;
          lin_next   = lin + 1'b1;
          state_next = (count == CNT_W'(1)) ? ST_FINISH : ST_PUT;
        end
      end
      ST_SCROLL: begin
        mem_we        = 1'b1;
        mem_waddr     = scr_addr;
        scr_addr_next = scr_addr + 1'b1;
        scr_cnt_next  = scr_cnt + 1'b1;
        if (scr_cnt == COL_W'(SCREEN_COLS - 1)) begin
          state_next = (count != '0) ? ST_PUT : ST_FINISH;
        end
      end
      ST_BKSP: begin
        mem_we     = 1'b1;
        mem_waddr  = phys_addr(lin - 1'b1, base_off);
        mem_wdata  = {attr, SPACE_CHAR};
        col_next   = col - 1'b1;
        lin_next   = lin - 1'b1;
        state_next = ST_FINISH;
      end
      ST_RDWAIT: begin
        res_data_next = mem_rdata;
        state_next    = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_next           = 1'b1;
          out_word_next.cursor_pos = lin_wide[POS_W-1:0];
          out_word_next.read_data  = res_data;
          out_word_next.scrolled   = did_scroll;
          state_next               = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // a new word enters from idle or as the finished one moves out
    if (accept) begin
      did_scroll_next = 1'b0;
      res_data_next   = '0;
      if (in_word.action == ACT_READ) begin
        if (cell_wide < 32'(CELL_COUNT)) begin
          mem_re     = 1'b1;
          state_next = ST_RDWAIT;
        end else begin
          state_next = ST_FINISH;
        end
      end else begin
        priority case (in_word.char_code)
          CHAR_NEWLINE: begin
            col_next   = '0;
            count_next = '0;
            if (row == ROW_W'(SCREEN_ROWS - 1)) begin
              lin_next        = LAST_ROW_START;
              scr_addr_next   = base_off;
              scr_cnt_next    = '0;
              base_off_next   = phys_addr(COLS_A, base_off);
              did_scroll_next = 1'b1;
              state_next      = ST_SCROLL;
            end else begin
              row_next   = row + 1'b1;
              lin_next   = lin - ADDR_W'(col) + COLS_A;
              state_next = ST_FINISH;
            end
          end
          CHAR_TAB: begin
            glyph_next = SPACE_CHAR;
            count_next = CNT_W'(TAB_WIDTH);
            state_next = ST_PUT;
          end
          CHAR_BACKSPACE: begin
            state_next = (col != '0) ? ST_BKSP : ST_FINISH;
          end
          default: begin
            glyph_next = in_word.char_code;
            count_next = CNT_W'(1);
            state_next = ST_PUT;
          end
        endcase
      end
    end
  end

endmodule

[design/tmtw_checker.sv]
// port level checker for the text mode terminal writer, bound to the top level
// depends on tmtw_pkg and text_mode_terminal_writer_macros.svh
`include "text_mode_terminal_writer_macros.svh"

module tmtw_checker
  import tmtw_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input out_word_t  out_word
);

  logic [1:0] pending;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // words accepted whose result has not yet left
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(in_acc) - 2'(out_acc);
    end
  end

  `TMTW_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word), "stalled output word changed")
  `TMTW_ASSERT_NOW(a_no_extra_word, out_valid || (pending == 2'd3), (pending != 2'd0) && (pending != 2'd3), "output word without a matching input word")
  `TMTW_ASSERT_NOW(a_scroll_is_put, out_valid && out_word.scrolled, out_word.read_data == '0, "scroll reported on a read word")
  `TMTW_ASSERT_NOW(a_cursor_range, out_valid, 32'(out_word.cursor_pos) < 32'(CELL_COUNT), "cursor outside the screen")
  `TMTW_ASSERT_NOW(a_clear_after_reset, $fell(rst), in_stall, "input taken during the clearing pass")

endmodule

bind text_mode_terminal_writer tmtw_checker u_tmtw_checker (.*);
